// ===== hdl/ppt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants for the projective point transform
// Widths, request kinds and the struct that travels down the cell chain.
// ----------------------------------------------------------------------------
package ppt_pkg;
   localparam int COORD_WIDTH = 16;
   localparam int COEF_WIDTH  = 48;
   localparam int FRAC_BITS   = 24;
   localparam int NUM_SLOTS   = 18;
   localparam int IDX_WIDTH   = 5;
   localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int DEN_WIDTH   = SUM_WIDTH - FRAC_BITS;
   localparam int QUO_WIDTH   = DEN_WIDTH;
   localparam int NUM_CELLS   = QUO_WIDTH;
   localparam int REQ_BYTES   = 11;
   localparam int RSP_BYTES   = 8;

   typedef enum logic {
      REQ_LOAD      = 1'b0,
      REQ_TRANSFORM = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                 vld;
      logic                 is_load;
      logic                 zero_den;
      logic                 neg_x;
      logic                 neg_y;
      logic [DEN_WIDTH-1:0] den;
      logic [DEN_WIDTH-1:0] num_x;
      logic [DEN_WIDTH-1:0] rem_x;
      logic [QUO_WIDTH-1:0] quo_x;
      logic [DEN_WIDTH-1:0] num_y;
      logic [DEN_WIDTH-1:0] rem_y;
      logic [QUO_WIDTH-1:0] quo_y;
   } div_slot_type;
endpackage
`default_nettype wire

// ===== hdl/projective_point_transform_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// projective_point_transform_top: 2-D point through one of two stored 3x3 matrices
// Coefficient loads and point transforms share one request stream.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                  | tuser
// req     | in  | coef_index, coef_value, in_x, in_y, direction | req_type
// rsp     | out | out_x, out_y                                | zero_denominator, saturated
//
// One item per cycle while the output stage is empty or rsp_tready is high; the response
// passes the product stage, the sum stage, one divider cell per quotient bit
// (42 cells) and one output stage.
// Synchronous reset empties the pipeline; the coefficient store is not reset.
// A stalled output freezes the whole chain; req_tready is high while the output stage is empty or rsp_tready is high.
module projective_point_transform_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [87:0] req_tdata,  // coef_index, coef_value, in_x, in_y, direction
   input  wire logic        req_tuser,  // req_type
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,  // out_x, out_y
   output      logic [1:0]  rsp_tuser   // zero_denominator, saturated
);
   import ppt_pkg::*;

   logic         en;
   div_slot_type chain [NUM_CELLS+1];
   logic         o_vld_ff;
   logic [31:0]  ox_ff, oy_ff;
   logic         zd_ff, sat_ff;
   logic [31:0]  ox, oy;
   logic         sx, sy;
   div_slot_type last;

   assign en         = !o_vld_ff || rsp_tready;
   assign req_tready = en;

   ppt_front u_front (
      .clock, .reset,
      .in_vld  (req_tvalid),
      .in_kind (req_tuser),
      .in_idx  (req_tdata[4:0]),
      .in_coef (req_tdata[52:5]),
      .in_x    (req_tdata[68:53]),
      .in_y    (req_tdata[84:69]),
      .in_dir  (req_tdata[85]),
      .en,
      .slot_out(chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ppt_div_cell u_cell (
         .clock, .reset, .en,
         .bit_pos (6'(QUO_WIDTH-1-i)),
         .slot_in (chain[i]),
         .slot_out(chain[i+1])
      );
   end

   assign last = chain[NUM_CELLS];

   always_comb begin
      sx = last.neg_x ? last.quo_x > QUO_WIDTH'(32'h80000000)
                      : last.quo_x > QUO_WIDTH'(32'h7FFFFFFF);
      sy = last.neg_y ? last.quo_y > QUO_WIDTH'(32'h80000000)
                      : last.quo_y > QUO_WIDTH'(32'h7FFFFFFF);
      ox = sx ? (last.neg_x ? 32'h80000000 : 32'h7FFFFFFF)
              : (last.neg_x ? -last.quo_x[31:0] : last.quo_x[31:0]);
      oy = sy ? (last.neg_y ? 32'h80000000 : 32'h7FFFFFFF)
              : (last.neg_y ? -last.quo_y[31:0] : last.quo_y[31:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff  <= last.zero_den ? '0 : ox;
         oy_ff  <= last.zero_den ? '0 : oy;
         zd_ff  <= last.zero_den && !last.is_load;
         sat_ff <= !last.zero_den && (sx || sy);
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {oy_ff, ox_ff};
   assign rsp_tuser  = {sat_ff, zd_ff};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("both flags set");
   a_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero denominator with nonzero coordinates");
endmodule
`default_nettype wire

// ===== hdl/ppt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_front: coefficient store and row sums
// Holds the 18 coefficients, forms the three row sums in two stages and
// hands magnitudes and signs to the divider chain.
// ----------------------------------------------------------------------------
module ppt_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_vld,
   input  wire logic                           in_kind,
   input  wire logic [ppt_pkg::IDX_WIDTH-1:0]  in_idx,
   input  wire logic [ppt_pkg::COEF_WIDTH-1:0] in_coef,
   input  wire logic [ppt_pkg::COORD_WIDTH-1:0] in_x,
   input  wire logic [ppt_pkg::COORD_WIDTH-1:0] in_y,
   input  wire logic                           in_dir,
   input  wire logic                           en,
   output ppt_pkg::div_slot_type               slot_out
);
   import ppt_pkg::*;

   logic [COEF_WIDTH-1:0] coef_ff [NUM_SLOTS];
   logic                  s1_vld_ff, s1_trn_ff;
   logic                  s2_vld_ff;
   logic [PROD_WIDTH-1:0] p_ff [6];
   logic [COEF_WIDTH-1:0] c_ff [3];
   logic [IDX_WIDTH-1:0]  base;
   logic [SUM_WIDTH-1:0]  s [3];
   logic [SUM_WIDTH-1:0]  a0, a1, a2;
   logic [DEN_WIDTH-1:0]  den;
   div_slot_type          slot_in, slot_ff;

   always_ff @(posedge clock) begin
      if (en && in_vld && in_kind == REQ_LOAD && in_idx < IDX_WIDTH'(NUM_SLOTS)) begin
         coef_ff[in_idx] <= in_coef;
      end
   end

   assign base = in_dir ? IDX_WIDTH'(9) : IDX_WIDTH'(0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_trn_ff <= in_kind == REQ_TRANSFORM;
         for (int r = 0; r < 3; r++) begin
            p_ff[2*r]   <= PROD_WIDTH'($signed(coef_ff[base+IDX_WIDTH'(3*r)])
                                       * $signed(in_x));
            p_ff[2*r+1] <= PROD_WIDTH'($signed(coef_ff[base+IDX_WIDTH'(3*r+1)])
                                       * $signed(in_y));
            c_ff[r]     <= coef_ff[base+IDX_WIDTH'(3*r+2)];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s[r] = SUM_WIDTH'($signed(p_ff[2*r])) + SUM_WIDTH'($signed(p_ff[2*r+1]))
              + SUM_WIDTH'($signed(c_ff[r]));
      end
      a0  = s[0][SUM_WIDTH-1] ? -s[0] : s[0];
      a1  = s[1][SUM_WIDTH-1] ? -s[1] : s[1];
      a2  = s[2][SUM_WIDTH-1] ? -s[2] : s[2];
      den = a2[SUM_WIDTH-1:FRAC_BITS];
      slot_in          = '0;
      slot_in.vld      = s1_vld_ff;
      slot_in.is_load  = !s1_trn_ff;
      slot_in.zero_den = !s1_trn_ff || den == '0;
      slot_in.den      = den;
      slot_in.num_x    = a0[SUM_WIDTH-1:FRAC_BITS];
      slot_in.num_y    = a1[SUM_WIDTH-1:FRAC_BITS];
      slot_in.neg_x    = s[0][SUM_WIDTH-1] ^ s[2][SUM_WIDTH-1];
      slot_in.neg_y    = s[1][SUM_WIDTH-1] ^ s[2][SUM_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= slot_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slot_ff <= slot_in;
      end
   end

   always_comb begin
      slot_out     = slot_ff;
      slot_out.vld = s2_vld_ff;
   end
endmodule
`default_nettype wire

// ===== hdl/ppt_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_div_cell: one restoring-division step for both coordinates
// Brings in one numerator bit per coordinate, produces one quotient bit each.
// ----------------------------------------------------------------------------
module ppt_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic [5:0]            bit_pos,
   input  wire ppt_pkg::div_slot_type slot_in,
   output ppt_pkg::div_slot_type      slot_out
);
   import ppt_pkg::*;

   div_slot_type         slot_in_w, slot_ff;
   logic                 vld_ff;
   logic [DEN_WIDTH:0]   tx, ty;

   always_comb begin
      slot_in_w = slot_in;
      tx = {slot_in.rem_x, slot_in.num_x[bit_pos]};
      ty = {slot_in.rem_y, slot_in.num_y[bit_pos]};
      slot_in_w.quo_x = {slot_in.quo_x[QUO_WIDTH-2:0], tx >= {1'b0, slot_in.den}};
      slot_in_w.quo_y = {slot_in.quo_y[QUO_WIDTH-2:0], ty >= {1'b0, slot_in.den}};
      slot_in_w.rem_x = DEN_WIDTH'(tx >= {1'b0, slot_in.den} ? tx - {1'b0, slot_in.den} : tx);
      slot_in_w.rem_y = DEN_WIDTH'(ty >= {1'b0, slot_in.den} ? ty - {1'b0, slot_in.den} : ty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= slot_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slot_ff <= slot_in_w;
      end
   end

   always_comb begin
      slot_out     = slot_ff;
      slot_out.vld = vld_ff;
   end
endmodule
`default_nettype wire
